>>> rtl/core/mcsc_pkg.sv
// ----------------------------------------------------------------------------
// mcsc_pkg
// Shared types, sizes and codes of the movie container stream checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsc_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int FIDX_W     = $clog2(MAX_FRAMES);
  localparam int FCNT_W     = $clog2(MAX_FRAMES + 1);

  // container constants
  localparam logic [31:0] HDR_LEN      = 32'd36;
  localparam logic [31:0] TRAILER_LEN  = 32'd16;
  localparam logic [31:0] MIN_LEN      = 32'd52;
  localparam logic [31:0] FRAME_HDR    = 32'd24;
  localparam logic [31:0] GEO_WIDTH    = 32'd256;
  localparam logic [31:0] GEO_HEIGHT   = 32'd192;
  localparam logic [31:0] VIDEO_RATE   = 32'd983035;
  localparam logic [31:0] AUDIO_RATE   = 32'd32768;
  localparam logic [31:0] AUDIO_BLOCK  = 32'd4608;
  localparam logic [31:0] AUDIO_SHORT  = 32'd320;
  localparam logic [31:0] AUDIO_LONG   = 32'd360;
  localparam logic [31:0] MIN_MAXSIZE  = 32'd8;

  // status codes
  localparam logic [4:0] ST_OK          = 5'd0;
  localparam logic [4:0] ST_SHORT       = 5'd1;
  localparam logic [4:0] ST_MAGIC       = 5'd2;
  localparam logic [4:0] ST_HDR_VALUE   = 5'd3;
  localparam logic [4:0] ST_MAXSIZE     = 5'd4;
  localparam logic [4:0] ST_TOTAL_NEG   = 5'd5;
  localparam logic [4:0] ST_LENGTH      = 5'd6;
  localparam logic [4:0] ST_FHDR_AREA   = 5'd7;
  localparam logic [4:0] ST_VIDEO_NEG   = 5'd8;
  localparam logic [4:0] ST_VIDEO_AREA  = 5'd9;
  localparam logic [4:0] ST_AUDIO_NEG   = 5'd10;
  localparam logic [4:0] ST_AUDIO_AREA  = 5'd11;
  localparam logic [4:0] ST_INDEX       = 5'd12;
  localparam logic [4:0] ST_SEEK        = 5'd13;
  localparam logic [4:0] ST_DATA_SIZE   = 5'd14;
  localparam logic [4:0] ST_AUDIO_SIZE  = 5'd15;
  localparam logic [4:0] ST_DATA_MAX    = 5'd16;
  localparam logic [4:0] ST_BACK_TARGET = 5'd17;
  localparam logic [4:0] ST_NO_MAX      = 5'd18;
  localparam logic [4:0] ST_FWD_TARGET  = 5'd19;
  localparam logic [4:0] ST_FRAMES_END  = 5'd20;
  localparam logic [4:0] ST_TRAILER     = 5'd21;
  localparam logic [4:0] ST_CAPACITY    = 5'd22;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        status;
    logic [FCNT_W-1:0] frames_parsed;
    logic              found_max_sized;
  } out_item_t;

  // offset search request and write port
  typedef struct packed {
    logic              start;
    logic [31:0]       key;
    logic [FCNT_W-1:0] count;
    logic              wr_en;
    logic [FIDX_W-1:0] wr_addr;
    logic [31:0]       wr_data;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h46;
      2'd1:    m = 8'h56;
      2'd2:    m = 8'h44;
      default: m = 8'h53;
    endcase
    return m;
  endfunction

  // keep the lowest error code seen so far
  function automatic logic [4:0] note_err(input logic [4:0] cur, input logic [4:0] code,
                                         input logic cond);
    logic [4:0] r;
    r = cur;
    if (cond && (cur == ST_OK || code < cur)) r = code;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mcsc_byte_cell.sv
// ----------------------------------------------------------------------------
// mcsc_byte_cell
// One byte cell of the word assembly chain; passes its byte on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsc_byte_cell (
  input  wire        clk,
  input  wire        shift,
  input  wire  [7:0] din,
  output logic [7:0] dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mcsc_word_chain.sv
// ----------------------------------------------------------------------------
// mcsc_word_chain
// Row of byte cells holding the three previous bytes; with the current byte
// they form a little-endian word.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsc_word_chain (
  input  wire         clk,
  input  wire         shift,
  input  wire  [7:0]  din,
  output logic [31:0] word
);

  localparam int NCELL = 3;

  logic [7:0] cell_q [NCELL];

  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      if (g == NCELL - 1) begin : g_top
        mcsc_byte_cell u_cell (.clk(clk), .shift(shift), .din(din), .dout(cell_q[g]));
      end else begin : g_mid
        mcsc_byte_cell u_cell (.clk(clk), .shift(shift), .din(cell_q[g+1]),
                               .dout(cell_q[g]));
      end
    end
  endgenerate

  assign word = {din, cell_q[2], cell_q[1], cell_q[0]};

endmodule

`default_nettype wire

>>> rtl/core/mcsc_search.sv
// ----------------------------------------------------------------------------
// mcsc_search
// Frame offset store with a binary search over the first count entries;
// offsets are strictly increasing; each probe reads the store, then compares.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsc_search (
  input  wire                clk,
  input  wire                rst,
  input  mcsc_pkg::srch_req_t req,
  output mcsc_pkg::srch_rsp_t rsp
);

  import mcsc_pkg::*;

  typedef enum logic [1:0] {Q_IDLE, Q_ISSUE, Q_CMP} qstate_t;

  qstate_t           qstate;
  logic [31:0]       mem [MAX_FRAMES];
  logic [31:0]       rd_q;
  logic [31:0]       key;
  logic [FCNT_W-1:0] lo;
  logic [FCNT_W-1:0] hi;
  logic [FCNT_W-1:0] mid;
  logic [FCNT_W:0]   sum;
  logic [FCNT_W-1:0] mid_next;

  assign sum      = {1'b0, lo} + {1'b0, hi};
  assign mid_next = sum[FCNT_W:1];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_q <= mem[mid_next[FIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qstate   <= Q_IDLE;
      rsp.done <= 1'b0;
      rsp.hit  <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (qstate)
        Q_IDLE: begin
          if (req.start) begin
            key    <= req.key;
            lo     <= '0;
            hi     <= req.count;
            qstate <= Q_ISSUE;
          end
        end
        Q_ISSUE: begin
          if (lo >= hi) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            qstate   <= Q_IDLE;
          end else begin
            mid    <= mid_next;
            qstate <= Q_CMP;
          end
        end
        Q_CMP: begin
          if (rd_q == key) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b1;
            qstate   <= Q_IDLE;
          end else begin
            if (rd_q < key) begin
              lo <= mid + 1'b1;
            end else begin
              hi <= mid;
            end
            qstate <= Q_ISSUE;
          end
        end
        default: qstate <= Q_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/movie_container_stream_checker_core.sv
// ----------------------------------------------------------------------------
// movie_container_stream_checker_core
// Byte-serial checker of an FVDS movie container: header, frames, trailer.
//
//   channel | direction | payload      | handshake
//   in      | input     | in_item_t    | in_valid / in_stall
//   out     | output    | out_item_t   | out_valid / out_stall
//
// One cycle per byte while the input is not stalled. At the end of each
// frame header's audio word the input stalls for the end-of-frame checks,
// plus a binary search over stored frame offsets when the frame seeks
// backward. After the last byte the result is formed in S_FIN, then, if no
// error was found, a sweep over all frames with a binary search per forward
// target, then S_END. Reset is synchronous; a delivered result returns the
// block to reset state. A stalled result also holds back the input bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module movie_container_stream_checker_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  mcsc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output mcsc_pkg::out_item_t out_item
);

  import mcsc_pkg::*;

  typedef enum logic [3:0] {
    S_RUN, S_CHECK, S_BACK, S_COMMIT, S_FIN, S_SW_RD, S_SW_CHK, S_SW_WAIT, S_END, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_HDR, PH_NEXT, PH_FHDR, PH_VIDEO, PH_AWORD, PH_AUDIO, PH_TAIL
  } phase_t;

  state_t            state;
  phase_t            phase;
  logic [31:0]       pos;
  logic [31:0]       hw_fc;
  logic [31:0]       hw_size;
  logic [31:0]       hw_max;
  logic [31:0]       fw_data;
  logic [31:0]       fw_back;
  logic [31:0]       fw_ahead;
  logic [31:0]       fw_idx;
  logic [31:0]       fw_vid;
  logic [31:0]       fw_aud;
  logic [31:0]       fpos;
  logic [31:0]       pl;
  logic [4:0]        cnt;
  logic [FCNT_W-1:0] fd;
  logic              max_seen;
  logic [4:0]        early;
  logic [4:0]        ferr;
  logic              trail;
  logic              last_pend;
  logic [FCNT_W-1:0] sw_idx;
  logic [4:0]        res_status;
  logic              res_hf;

  logic [31:0]       tgt_mem [MAX_FRAMES];
  logic [31:0]       tgt_q;

  logic              accept;
  logic [31:0]       word;
  logic [31:0]       area;
  logic [7:0]        b;

  // per-byte next values
  phase_t            phase_next;
  logic [31:0]       hw_fc_next, hw_size_next, hw_max_next;
  logic [31:0]       fw_data_next, fw_back_next, fw_ahead_next, fw_idx_next, fw_vid_next;
  logic [31:0]       fw_aud_next, fpos_next, pl_next;
  logic [4:0]        cnt_next, early_next, ferr_next;
  logic              trail_next;
  logic              go_check;

  // frame checks
  logic [4:0]        chk_code;
  logic [33:0]       back_t;
  logic [32:0]       ahead_t;
  logic [31:0]       tgt_val;
  logic              done_all;

  srch_req_t         sreq;
  srch_rsp_t         srsp;

  assign b      = in_item.data_byte;
  assign area   = HDR_LEN + {1'b0, hw_size[30:0]};
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_RUN) || (out_valid && out_stall);

  assign done_all = $signed({20'd0, fd}) >= $signed({hw_fc[31], hw_fc});

  mcsc_word_chain u_chain (.clk(clk), .shift(accept), .din(b), .word(word));

  mcsc_search u_search (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  always_comb begin
    phase_t     eff;
    logic [4:0] e;
    logic [31:0] rp20;
    phase_next    = phase;
    hw_fc_next    = hw_fc;
    hw_size_next  = hw_size;
    hw_max_next   = hw_max;
    fw_data_next  = fw_data;
    fw_back_next  = fw_back;
    fw_ahead_next = fw_ahead;
    fw_idx_next   = fw_idx;
    fw_vid_next   = fw_vid;
    fw_aud_next   = fw_aud;
    fpos_next     = fpos;
    pl_next       = pl;
    cnt_next      = cnt + 5'd1;
    early_next    = early;
    ferr_next     = ferr;
    trail_next    = trail;
    go_check      = 1'b0;
    e             = early;
    rp20          = area - fpos - 32'd20;
    eff           = phase;
    if (phase == PH_NEXT) begin
      if (done_all) begin
        eff        = PH_TAIL;
        phase_next = PH_TAIL;
      end else if (fpos > area || (area - fpos) < FRAME_HDR) begin
        ferr_next  = ST_FHDR_AREA;
        eff        = PH_TAIL;
        phase_next = PH_TAIL;
      end else begin
        eff        = PH_FHDR;
        phase_next = PH_FHDR;
      end
    end
    case (eff)
      PH_HDR: begin
        if (pos[5:0] < 6'd4) begin
          e = note_err(e, ST_MAGIC, b != magic_byte(pos[1:0]));
        end else if (pos[1:0] == 2'd3) begin
          case (pos[5:2])
            4'd1: begin
              hw_fc_next = word;
              e = note_err(e, ST_HDR_VALUE, word[31] || word == 32'd0);
              e = note_err(e, ST_CAPACITY, !word[31] && word > 32'(MAX_FRAMES));
            end
            4'd2: e = note_err(e, ST_HDR_VALUE, word != GEO_WIDTH);
            4'd3: e = note_err(e, ST_HDR_VALUE, word != GEO_HEIGHT);
            4'd4: e = note_err(e, ST_HDR_VALUE, word != VIDEO_RATE);
            4'd5: e = note_err(e, ST_HDR_VALUE, word != AUDIO_RATE);
            4'd6: hw_size_next = word;
            4'd7: hw_max_next = word;
            default: e = note_err(e, ST_HDR_VALUE, word != AUDIO_BLOCK);
          endcase
        end
        if (pos[5:0] == 6'd35) begin
          e = note_err(e, ST_MAXSIZE, $signed(hw_max) < $signed(MIN_MAXSIZE));
          e = note_err(e, ST_TOTAL_NEG, hw_size[31]);
          fpos_next  = HDR_LEN;
          cnt_next   = 5'd0;
          phase_next = (e != ST_OK) ? PH_TAIL : PH_NEXT;
        end
        early_next = e;
      end
      PH_FHDR: begin
        if (cnt[1:0] == 2'd3) begin
          case (cnt[4:2])
            3'd0:    fw_data_next  = word;
            3'd1:    fw_back_next  = word;
            3'd2:    fw_ahead_next = word;
            3'd3:    fw_idx_next   = word;
            default: fw_vid_next   = word;
          endcase
        end
        if (cnt == 5'd19) begin
          cnt_next = 5'd0;
          if (word[31]) begin
            ferr_next  = ST_VIDEO_NEG;
            phase_next = PH_TAIL;
          end else if (word > rp20 || (rp20 - word) < 32'd4) begin
            ferr_next  = ST_VIDEO_AREA;
            phase_next = PH_TAIL;
          end else begin
            pl_next    = word;
            phase_next = (word != 32'd0) ? PH_VIDEO : PH_AWORD;
          end
        end
      end
      PH_VIDEO: begin
        pl_next  = pl - 32'd1;
        cnt_next = 5'd0;
        if (pl == 32'd1) phase_next = PH_AWORD;
      end
      PH_AWORD: begin
        if (cnt == 5'd3) begin
          fw_aud_next = word;
          go_check    = 1'b1;
        end
      end
      PH_AUDIO: begin
        pl_next  = pl - 32'd1;
        cnt_next = 5'd0;
        if (pl == 32'd1) phase_next = PH_NEXT;
      end
      PH_TAIL: begin
        if (pos >= area && (pos - area) < TRAILER_LEN && b != 8'd0) trail_next = 1'b1;
      end
      default: ;
    endcase
  end

  // end-of-frame checks, first failing one wins
  always_comb begin
    logic [33:0] vsum;
    logic [33:0] fcm1;
    vsum    = {2'b0, fw_vid} + {2'b0, fw_aud} + 34'd8;
    fcm1    = {{2{hw_fc[31]}}, hw_fc} - 34'd1;
    back_t  = {2'b0, fpos} + {{2{fw_back[31]}}, fw_back};
    ahead_t = {1'b0, fpos} + {1'b0, fw_ahead};
    tgt_val = ahead_t[32] ? 32'hFFFF_FFFF : ahead_t[31:0];
    if (fw_ahead[31] || fw_ahead == 32'd0) tgt_val = 32'd0;
    chk_code = ST_OK;
    if (fw_aud[31]) begin
      chk_code = ST_AUDIO_NEG;
    end else if (fw_aud > (area - fpos - FRAME_HDR - fw_vid)) begin
      chk_code = ST_AUDIO_AREA;
    end else if (fw_idx != {19'd0, fd}) begin
      chk_code = ST_INDEX;
    end else if ((!fw_back[31] && fw_back != 32'd0) ||
                 (fd == '0 && fw_back != 32'd0) ||
                 (fcm1 == {21'd0, fd} && !fw_ahead[31] && fw_ahead != 32'd0)) begin
      chk_code = ST_SEEK;
    end else if (fw_data[31] || {2'b0, fw_data} != vsum) begin
      chk_code = ST_DATA_SIZE;
    end else if (fw_aud != AUDIO_SHORT && fw_aud != AUDIO_LONG) begin
      chk_code = ST_AUDIO_SIZE;
    end else if ($signed(fw_data) > $signed(hw_max)) begin
      chk_code = ST_DATA_MAX;
    end else if (fw_back[31] && back_t[33]) begin
      chk_code = ST_BACK_TARGET;
    end
  end

  always_comb begin
    sreq         = '0;
    sreq.count   = fd;
    sreq.wr_addr = fd[FIDX_W-1:0];
    sreq.wr_data = fpos;
    sreq.key     = (state == S_CHECK) ? back_t[31:0] : tgt_q;
    case (state)
      S_CHECK:  sreq.start = (chk_code == ST_OK) && fw_back[31];
      S_SW_CHK: sreq.start = (sw_idx < fd) && (tgt_q != 32'd0);
      S_COMMIT: sreq.wr_en = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_COMMIT) begin
      tgt_mem[fd[FIDX_W-1:0]] <= tgt_val;
    end
    tgt_q <= tgt_mem[sw_idx[FIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      phase     <= PH_HDR;
      pos       <= '0;
      hw_fc     <= '0;
      hw_size   <= '0;
      hw_max    <= '0;
      fpos      <= HDR_LEN;
      pl        <= '0;
      cnt       <= '0;
      fd        <= '0;
      max_seen  <= 1'b0;
      early     <= ST_OK;
      ferr      <= ST_OK;
      trail     <= 1'b0;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_RUN: begin
          if (accept) begin
            phase    <= phase_next;
            hw_fc    <= hw_fc_next;
            hw_size  <= hw_size_next;
            hw_max   <= hw_max_next;
            fw_data  <= fw_data_next;
            fw_back  <= fw_back_next;
            fw_ahead <= fw_ahead_next;
            fw_idx   <= fw_idx_next;
            fw_vid   <= fw_vid_next;
            fw_aud   <= fw_aud_next;
            fpos     <= fpos_next;
            pl       <= pl_next;
            cnt      <= cnt_next;
            early    <= early_next;
            ferr     <= ferr_next;
            trail    <= trail_next;
            if (pos != 32'hFFFF_FFFF) pos <= pos + 32'd1;
            last_pend <= in_item.last_byte;
            if (go_check) begin
              state <= S_CHECK;
            end else if (in_item.last_byte) begin
              state <= S_FIN;
            end
          end
        end
        S_CHECK: begin
          if (chk_code != ST_OK) begin
            ferr  <= chk_code;
            phase <= PH_TAIL;
            state <= last_pend ? S_FIN : S_RUN;
          end else if (fw_back[31]) begin
            state <= S_BACK;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_BACK: begin
          if (srsp.done) begin
            if (srsp.hit) begin
              state <= S_COMMIT;
            end else begin
              ferr  <= ST_BACK_TARGET;
              phase <= PH_TAIL;
              state <= last_pend ? S_FIN : S_RUN;
            end
          end
        end
        S_COMMIT: begin
          if (fw_data == hw_max) max_seen <= 1'b1;
          fd    <= fd + 1'b1;
          fpos  <= fpos + FRAME_HDR + fw_vid + fw_aud;
          pl    <= fw_aud;
          phase <= PH_AUDIO;
          state <= last_pend ? S_FIN : S_RUN;
        end
        S_FIN: begin
          res_hf <= 1'b1;
          state  <= S_OUT;
          if (pos < MIN_LEN) begin
            res_status <= ST_SHORT;
          end else if (early >= ST_MAGIC && early <= ST_TOTAL_NEG) begin
            res_status <= early;
          end else if (pos - MIN_LEN != hw_size) begin
            res_status <= ST_LENGTH;
          end else if (early != ST_OK) begin
            res_status <= early;
          end else begin
            res_hf <= 1'b0;
            if (ferr != ST_OK) begin
              res_status <= ferr;
            end else if (!done_all) begin
              res_status <= ST_FHDR_AREA;
            end else if (!max_seen) begin
              res_status <= ST_NO_MAX;
            end else begin
              sw_idx <= '0;
              state  <= S_SW_RD;
            end
          end
        end
        S_SW_RD: begin
          state <= S_SW_CHK;
        end
        S_SW_CHK: begin
          if (sw_idx >= fd) begin
            state <= S_END;
          end else if (tgt_q == 32'd0) begin
            sw_idx <= sw_idx + 1'b1;
            state  <= S_SW_RD;
          end else begin
            state <= S_SW_WAIT;
          end
        end
        S_SW_WAIT: begin
          if (srsp.done) begin
            if (srsp.hit) begin
              sw_idx <= sw_idx + 1'b1;
              state  <= S_SW_RD;
            end else begin
              res_status <= ST_FWD_TARGET;
              state      <= S_OUT;
            end
          end
        end
        S_END: begin
          if (fpos != area) begin
            res_status <= ST_FRAMES_END;
          end else if (trail) begin
            res_status <= ST_TRAILER;
          end else begin
            res_status <= ST_OK;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!(out_valid && out_stall)) begin
            out_valid                <= 1'b1;
            out_item.status          <= res_status;
            out_item.frames_parsed   <= res_hf ? '0 : fd;
            out_item.found_max_sized <= !res_hf && max_seen;
            phase    <= PH_HDR;
            pos      <= '0;
            hw_fc    <= '0;
            hw_size  <= '0;
            hw_max   <= '0;
            fpos     <= HDR_LEN;
            pl       <= '0;
            cnt      <= '0;
            fd       <= '0;
            max_seen <= 1'b0;
            early    <= ST_OK;
            ferr     <= ST_OK;
            trail    <= 1'b0;
            state    <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

`default_nettype wire
